@@ hw/rtl/hsv2rgb_pkg.sv @@
package hsv2rgb_pkg;

    localparam int FRAC_BITS = 12;
    localparam int HUE_BITS  = 16;
    localparam int CH_W      = FRAC_BITS + 1;
    localparam int PROD_W    = 2 * CH_W;
    localparam int SECTOR_W  = 3;
    localparam int ROM_DEPTH = (1 << FRAC_BITS) + 1;
    localparam int ROM_AW    = $clog2(ROM_DEPTH);

    localparam logic [CH_W-1:0] ONE = CH_W'(1 << FRAC_BITS);

    localparam longint unsigned LIN_DEN = 64'd10 * 64'(ONE);

    typedef struct packed {
        logic [15:0] hue;
        logic [12:0] saturation;
        logic [12:0] brightness;
    } hsv_beat_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_beat_t;

    typedef logic [ROM_DEPTH-1:0][7:0] gamma_rom_t;

    // Entry i = round-half-up of 255 * oetf(i / ONE), exact integer arithmetic.
    function automatic gamma_rom_t build_gamma_rom();
        gamma_rom_t       rom;
        logic [255:0]     base;
        logic [255:0]     rhs;
        logic [255:0]     lhs;
        longint unsigned  lin;
        longint unsigned  num;
        int unsigned      k;
        logic             reach;
        rom  = '0;
        base = 256'd1;
        k    = 0;
        for (int n = 0; n < 12; n++)
        begin
            base = base * 256'd10761;
        end
        for (int i = 0; i < ROM_DEPTH; i++)
        begin
            if (64'(i) * 64'd10000000 <= 64'd31308 * 64'(ONE))
            begin
                num = 64'd32946 * 64'(i) + 64'd5 * 64'(ONE);
                lin = 64'd0;
                while (num >= LIN_DEN)
                begin
                    num = num - LIN_DEN;
                    lin = lin + 64'd1;
                end
                rom[i] = lin[7:0];
            end
            else
            begin
                rhs = base;
                for (int n = 0; n < 5; n++)
                begin
                    rhs = rhs * 256'(i);
                end
                reach = 1'b1;
                while (reach && k < 255)
                begin
                    lhs = 256'd1;
                    for (int n = 0; n < 12; n++)
                    begin
                        lhs = lhs * 256'(40 * k + 581);
                    end
                    lhs = lhs << (5 * FRAC_BITS);
                    if (rhs >= lhs)
                    begin
                        k++;
                    end
                    else
                    begin
                        reach = 1'b0;
                    end
                end
                rom[i] = 8'(k);
            end
        end
        return rom;
    endfunction

endpackage

@@ hw/rtl/hsv2rgb_gamma_rom.sv @@
module hsv2rgb_gamma_rom (
    input  logic                           clk,
    input  logic                           en,
    input  logic [hsv2rgb_pkg::ROM_AW-1:0] addr,
    output logic [7:0]                     data
);

    localparam hsv2rgb_pkg::gamma_rom_t ROM = hsv2rgb_pkg::build_gamma_rom();

    logic [7:0] data_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= ROM[addr];
        end
    end

    assign data = data_reg;

endmodule

@@ hw/rtl/hsv_to_srgb_pixel_top.sv @@
// Throughput: one pixel per cycle; the five stages advance together and
// freeze as a whole while a finished rgb beat is held by rgb_stall.
// Stages: sector/clamp, two products, third product, channel swap, sRGB ROM.
// Reset: rst_n low clears all stage valid bits asynchronously; no other state.
module hsv_to_srgb_pixel_top (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   hsv_valid,
    output logic                   hsv_stall,
    input  hsv2rgb_pkg::hsv_beat_t hsv,
    output logic                   rgb_valid,
    input  logic                   rgb_stall,
    output hsv2rgb_pkg::rgb_beat_t rgb
);

    localparam int CH_W   = hsv2rgb_pkg::CH_W;
    localparam int PROD_W = hsv2rgb_pkg::PROD_W;
    localparam int SW     = hsv2rgb_pkg::SECTOR_W;
    localparam int FB     = hsv2rgb_pkg::FRAC_BITS;
    localparam int HB     = hsv2rgb_pkg::HUE_BITS;
    localparam int H6_W   = HB + SW;
    localparam logic [CH_W-1:0] ONE = hsv2rgb_pkg::ONE;

    localparam logic [SW-1:0] SECT_RED_YEL = SW'(0);
    localparam logic [SW-1:0] SECT_YEL_GRN = SW'(1);
    localparam logic [SW-1:0] SECT_GRN_CYN = SW'(2);
    localparam logic [SW-1:0] SECT_CYN_BLU = SW'(3);
    localparam logic [SW-1:0] SECT_BLU_MAG = SW'(4);

    logic              adv;
    logic [4:0]        vld_reg;
    logic [4:0]        vld_next;

    logic [H6_W-1:0]   h6;
    logic [FB-1:0]     frac;
    logic [CH_W-1:0]   s1_sat_next, s1_sat_reg;
    logic [CH_W-1:0]   s1_val_next, s1_val_reg;
    logic [CH_W-1:0]   s1_f_next,   s1_f_reg;
    logic [SW-1:0]     s1_sec_next, s1_sec_reg;

    logic [PROD_W-1:0] sf_prod, m_prod;
    logic [CH_W-1:0]   s2_sf_next,  s2_sf_reg;
    logic [CH_W-1:0]   s2_m_next,   s2_m_reg;
    logic [CH_W-1:0]   s2_val_reg;
    logic [SW-1:0]     s2_sec_reg;

    logic [PROD_W-1:0] x_prod;
    logic [CH_W-1:0]   s3_x_next,   s3_x_reg;
    logic [CH_W-1:0]   s3_m_reg,    s3_val_reg;
    logic [SW-1:0]     s3_sec_reg;

    logic [CH_W-1:0]   r_next, g_next, b_next;
    logic [CH_W-1:0]   r_reg,  g_reg,  b_reg;

    assign adv       = !(vld_reg[4] && rgb_stall);
    assign hsv_stall = !adv;
    assign vld_next  = {vld_reg[3:0], hsv_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= vld_next;
        end
    end

    // sector and fraction, clamp inputs
    always_comb
    begin
        h6          = H6_W'(hsv.hue[HB-1:0]) * H6_W'(6);
        frac        = h6[HB-1 -: FB];
        s1_sec_next = h6[H6_W-1:HB];
        s1_f_next   = s1_sec_next[0] ? {1'b0, frac} : ONE - {1'b0, frac};
        s1_sat_next = (hsv.saturation > ONE) ? ONE : hsv.saturation;
        s1_val_next = (hsv.brightness > ONE) ? ONE : hsv.brightness;
    end

    // s*f and v*(1-s)
    always_comb
    begin
        sf_prod    = PROD_W'(s1_sat_reg) * PROD_W'(s1_f_reg);
        m_prod     = PROD_W'(s1_val_reg) * PROD_W'(ONE - s1_sat_reg);
        s2_sf_next = sf_prod[FB +: CH_W];
        s2_m_next  = m_prod[FB +: CH_W];
    end

    // v*(1-s*f)
    always_comb
    begin
        x_prod    = PROD_W'(s2_val_reg) * PROD_W'(ONE - s2_sf_reg);
        s3_x_next = x_prod[FB +: CH_W];
    end

    always_comb
    begin
        unique case (s3_sec_reg)
            SECT_RED_YEL:
            begin
                r_next = s3_val_reg; g_next = s3_x_reg;   b_next = s3_m_reg;
            end
            SECT_YEL_GRN:
            begin
                r_next = s3_x_reg;   g_next = s3_val_reg; b_next = s3_m_reg;
            end
            SECT_GRN_CYN:
            begin
                r_next = s3_m_reg;   g_next = s3_val_reg; b_next = s3_x_reg;
            end
            SECT_CYN_BLU:
            begin
                r_next = s3_m_reg;   g_next = s3_x_reg;   b_next = s3_val_reg;
            end
            SECT_BLU_MAG:
            begin
                r_next = s3_x_reg;   g_next = s3_m_reg;   b_next = s3_val_reg;
            end
            default:
            begin
                r_next = s3_val_reg; g_next = s3_m_reg;   b_next = s3_x_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_sat_reg <= s1_sat_next;
            s1_val_reg <= s1_val_next;
            s1_f_reg   <= s1_f_next;
            s1_sec_reg <= s1_sec_next;

            s2_sf_reg  <= s2_sf_next;
            s2_m_reg   <= s2_m_next;
            s2_val_reg <= s1_val_reg;
            s2_sec_reg <= s1_sec_reg;

            s3_x_reg   <= s3_x_next;
            s3_m_reg   <= s2_m_reg;
            s3_val_reg <= s2_val_reg;
            s3_sec_reg <= s2_sec_reg;

            r_reg      <= r_next;
            g_reg      <= g_next;
            b_reg      <= b_next;
        end
    end

    hsv2rgb_gamma_rom u_rom_red (
        .clk  (clk),
        .en   (adv),
        .addr (r_reg),
        .data (rgb.red)
    );

    hsv2rgb_gamma_rom u_rom_green (
        .clk  (clk),
        .en   (adv),
        .addr (g_reg),
        .data (rgb.green)
    );

    hsv2rgb_gamma_rom u_rom_blue (
        .clk  (clk),
        .en   (adv),
        .addr (b_reg),
        .data (rgb.blue)
    );

    assign rgb_valid = vld_reg[4];

endmodule

@@ hw/rtl/hsv2rgb_checker.sv @@
module hsv2rgb_checker (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   hsv_valid,
    input logic                   hsv_stall,
    input hsv2rgb_pkg::hsv_beat_t hsv,
    input logic                   rgb_valid,
    input logic                   rgb_stall,
    input hsv2rgb_pkg::rgb_beat_t rgb
);

    logic hsv_acc;

    assign hsv_acc = hsv_valid && !hsv_stall;

    // hold a stalled beat
    a_rgb_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rgb_valid && rgb_stall |=> rgb_valid && $stable(rgb))
        else $error("rgb beat changed while stalled");

    a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
        hsv_stall == (rgb_valid && rgb_stall))
        else $error("input stall does not follow output backpressure");

    a_black: assert property (@(posedge clk) disable iff (!rst_n)
        hsv_acc && hsv.brightness == 13'd0
        ##1 !rgb_stall ##1 !rgb_stall ##1 !rgb_stall ##1 !rgb_stall
        |=> rgb_valid && rgb.red == 8'd0 && rgb.green == 8'd0 && rgb.blue == 8'd0)
        else $error("zero brightness did not give black");

    a_white: assert property (@(posedge clk) disable iff (!rst_n)
        hsv_acc && hsv.brightness == 13'd4096 && hsv.saturation == 13'd0
        ##1 !rgb_stall ##1 !rgb_stall ##1 !rgb_stall ##1 !rgb_stall
        |=> rgb_valid && rgb.red == 8'd255 && rgb.green == 8'd255 && rgb.blue == 8'd255)
        else $error("full brightness gray did not give white");

endmodule

bind hsv_to_srgb_pixel_top hsv2rgb_checker u_hsv2rgb_checker (.*);
